>>> sv/fsr_pkg.sv
// fsr_pkg: shared constants and types for the fraction sum reducer
// no dependencies
package fsr_pkg;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned IoWidth    = 32;
endpackage

>>> sv/fsr_if.sv
// fsr_if: valid/ready channels for input and result beats
// depends on fsr_pkg
interface fsr_in_if;
  logic valid;
  logic ready;
  logic signed [fsr_pkg::IoWidth-1:0] numerator;
  logic signed [fsr_pkg::IoWidth-1:0] denominator;
  logic last;
  modport source (output valid, numerator, denominator, last, input ready);
  modport sink (input valid, numerator, denominator, last, output ready);
endinterface

interface fsr_out_if;
  logic valid;
  logic ready;
  logic signed [fsr_pkg::IoWidth-1:0] sum_numerator;
  logic signed [fsr_pkg::IoWidth-1:0] sum_denominator;
  logic overflow;
  logic zero_divisor;
  modport source (output valid, sum_numerator, sum_denominator, overflow, zero_divisor,
    input ready);
  modport sink (input valid, sum_numerator, sum_denominator, overflow, zero_divisor,
    output ready);
endinterface

>>> sv/fsr_mul.sv
// fsr_mul: bit-serial shift-add signed multiplier with overflow detect
// depends on fsr_pkg
module fsr_mul #(
  parameter int unsigned W = fsr_pkg::ValueWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         done_o,
  output logic [W-1:0] p_o,
  output logic         ovf_o
);
  localparam int unsigned CW = $clog2(W+1);
  logic [2*W-1:0] acc_q, acc_d;
  logic [W-1:0] mb_q, mb_d, ma_q, ma_d;
  logic neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0] ma, mb, mag;
  logic [2*W-1:0] sum;

  assign ma = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign mb = b_i[W-1] ? (~b_i + W'(1)) : b_i;
  // add at top half then shift right one bit a cycle
  assign sum = {({1'b0, acc_q[2*W-1:W]} + (mb_q[0] ? {1'b0, ma_q} : '0)), acc_q[W-1:1]};

  always_comb begin
    acc_d = acc_q; mb_d = mb_q; ma_d = ma_q; neg_d = neg_q;
    busy_d = busy_q; cnt_d = cnt_q; done_d = 1'b0;
    if (start_i) begin
      acc_d = '0; ma_d = ma; mb_d = mb; neg_d = a_i[W-1] ^ b_i[W-1];
      busy_d = 1'b1; cnt_d = '0;
    end else if (busy_q) begin
      acc_d = sum; mb_d = mb_q >> 1; cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W-1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mb_q <= mb_d; ma_q <= ma_d; neg_q <= neg_d;
  end

  assign mag = acc_q[W-1:0];
  assign done_o = done_q;
  assign p_o = neg_q ? (~mag + W'(1)) : mag;
  always_comb begin
    if (acc_q[2*W-1:W] != '0) ovf_o = 1'b1;
    else if (neg_q) ovf_o = mag > {1'b1, {(W-1){1'b0}}};
    else ovf_o = mag[W-1];
  end
endmodule

>>> sv/fsr_div.sv
// fsr_div: bit-serial restoring divider for magnitudes, quotient and remainder
// depends on fsr_pkg
module fsr_div #(
  parameter int unsigned W = fsr_pkg::ValueWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         done_o,
  output logic [W-1:0] q_o,
  output logic [W-1:0] r_o
);
  localparam int unsigned CW = $clog2(W+1);
  logic [W-1:0] q_q, q_d, b_q, b_d;
  logic [W:0] r_q, r_d, t;
  logic busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign t = {r_q[W-1:0], q_q[W-1]};
  always_comb begin
    q_d = q_q; r_d = r_q; b_d = b_q; busy_d = busy_q; cnt_d = cnt_q; done_d = 1'b0;
    if (start_i) begin
      q_d = a_i; r_d = '0; b_d = b_i; busy_d = 1'b1; cnt_d = '0;
    end else if (busy_q) begin
      if (t >= {1'b0, b_q}) begin
        r_d = t - {1'b0, b_q}; q_d = {q_q[W-2:0], 1'b1};
      end else begin
        r_d = t; q_d = {q_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W-1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; b_q <= b_d;
  end
  assign done_o = done_q;
  assign q_o = q_q;
  assign r_o = r_q[W-1:0];
endmodule

>>> sv/fraction_sum_reducer.sv
// fraction_sum_reducer: rational accumulate with euclid gcd reduction
// a beat takes three serial multiplies on the shared multiplier; a last beat
// then runs euclid steps, a final zero check, the two final divisions and a
// load of the result beat; one item at a time, set by the shared multiplier
// and divider
// async active-low reset clears the sum to 0/1, overflow flag and control
module fraction_sum_reducer #(
  parameter int unsigned VALUE_WIDTH = fsr_pkg::ValueWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  fsr_in_if.sink    in_i,
  fsr_out_if.source out_o
);
  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned IW = fsr_pkg::IoWidth;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_M1    = 10'b0000000010,
    S_M2    = 10'b0000000100,
    S_M3    = 10'b0000001000,
    S_GCHK  = 10'b0000010000,
    S_GDIV  = 10'b0000100000,
    S_DN    = 10'b0001000000,
    S_DD    = 10'b0010000000,
    S_OUTF  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [W-1:0] accn_q, accn_d, accd_q, accd_d;
  logic [W-1:0] n_q, n_d, d_q, d_d, t1_q, t1_d, num_q, num_d, den_q, den_d;
  logic [W-1:0] ga_q, ga_d, gb_q, gb_d;
  logic ovf_q, ovf_d, last_q, last_d, zd_q, zd_d;
  logic [IW-1:0] on_q, on_d, od_q, od_d;
  logic ov_q, ov_d, oz_q, oz_d, ovld_q, ovld_d;

  // shared multiplier
  logic m_start, m_done, m_ovf;
  logic [W-1:0] m_a, m_b, m_p;
  fsr_mul #(.W(W)) u_mul (.clk_i, .rst_ni, .start_i(m_start), .a_i(m_a), .b_i(m_b),
    .done_o(m_done), .p_o(m_p), .ovf_o(m_ovf));

  // shared divider on magnitudes
  logic v_start, v_done;
  logic [W-1:0] v_a, v_b, v_q, v_r, v_sa, v_sb;
  fsr_div #(.W(W)) u_div (.clk_i, .rst_ni, .start_i(v_start), .a_i(v_a), .b_i(v_b),
    .done_o(v_done), .q_o(v_q), .r_o(v_r));

  logic [W-1:0] sgn_w;
  assign sgn_w = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] fmag(input logic [W-1:0] v);
    fmag = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  // input conversion to value width
  logic [W-1:0] n_in, d_in;
  logic in_ovf;
  logic [IW:0] ext_n, ext_d;
  always_comb begin
    ext_n = {in_i.numerator[IW-1], in_i.numerator};
    ext_d = {in_i.denominator[IW-1], in_i.denominator};
    if (W >= IW) begin
      n_in = W'($signed(ext_n));
      d_in = W'($signed(ext_d));
      in_ovf = 1'b0;
    end else begin
      n_in = W'(ext_n);
      d_in = W'(ext_d);
      in_ovf = ($signed((IW+1)'($signed(n_in))) != $signed(ext_n))
            || ($signed((IW+1)'($signed(d_in))) != $signed(ext_d));
    end
  end

  // output conversion, flags values that do not fit 32 bits
  function automatic logic out_bad(input logic [W-1:0] v);
    logic [W:0] e;
    e = {v[W-1], v};
    if (W <= IW) out_bad = 1'b0;
    else out_bad = ($signed((W+1)'($signed(IW'(v)))) != $signed(e));
  endfunction
  function automatic logic [IW-1:0] to_out(input logic [W-1:0] v);
    logic [IW:0] e;
    e = (IW+1)'($signed({v[W-1], v}));
    to_out = e[IW-1:0];
  endfunction

  logic [W-1:0] addr;
  logic add_ovf;
  assign addr = t1_q + m_p;
  assign add_ovf = (t1_q[W-1] == m_p[W-1]) && (addr[W-1] != t1_q[W-1]);

  logic [W-1:0] gq;
  logic gq_ovf;
  always_comb begin
    // signed quotient from magnitude quotient and sign of dividend vs divisor ga
    if (v_sa[W-1] ^ v_sb[W-1]) begin
      gq = ~v_q + W'(1);
      gq_ovf = v_q > sgn_w;
    end else begin
      gq = v_q;
      gq_ovf = v_q[W-1];
    end
  end
  logic [W-1:0] sa_q, sa_d, sb_q, sb_d;
  assign v_sa = sa_q;
  assign v_sb = sb_q;

  always_comb begin
    state_d = state_q; accn_d = accn_q; accd_d = accd_q; n_d = n_q; d_d = d_q;
    t1_d = t1_q; num_d = num_q; den_d = den_q; ga_d = ga_q; gb_d = gb_q;
    ovf_d = ovf_q; last_d = last_q; zd_d = zd_q; sa_d = sa_q; sb_d = sb_q;
    on_d = on_q; od_d = od_q; ov_d = ov_q; oz_d = oz_q; ovld_d = ovld_q;
    m_start = 1'b0; m_a = accn_q; m_b = d_q;
    v_start = 1'b0; v_a = fmag(ga_q); v_b = fmag(gb_q);
    if (out_o.valid && out_o.ready) ovld_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          n_d = n_in; d_d = d_in; last_d = in_i.last;
          ovf_d = ovf_q | in_ovf;
          m_start = 1'b1; m_a = accn_q; m_b = d_in;
          state_d = S_M1;
        end
      end
      S_M1: begin
        m_a = n_q; m_b = accd_q;
        if (m_done) begin
          t1_d = m_p; ovf_d = ovf_q | m_ovf; m_start = 1'b1; state_d = S_M2;
        end
      end
      S_M2: begin
        m_a = accd_q; m_b = d_q;
        if (m_done) begin
          num_d = addr; ovf_d = ovf_q | m_ovf | add_ovf; m_start = 1'b1; state_d = S_M3;
        end
      end
      S_M3: begin
        if (m_done) begin
          den_d = m_p; ovf_d = ovf_q | m_ovf;
          if (!last_q) begin
            accn_d = num_q; accd_d = m_p; state_d = S_IDLE;
          end else begin
            ga_d = num_q; gb_d = m_p; state_d = S_GCHK;
          end
        end
      end
      S_GCHK: begin
        if (gb_q == '0) begin
          if (ga_q == '0) begin
            zd_d = 1'b1; state_d = S_OUTF;
          end else begin
            zd_d = 1'b0; v_start = 1'b1; v_a = fmag(num_q); v_b = fmag(ga_q);
            sa_d = num_q; sb_d = ga_q; state_d = S_DN;
          end
        end else begin
          v_start = 1'b1; state_d = S_GDIV;
        end
      end
      S_GDIV: begin
        if (v_done) begin
          // remainder takes the dividend's sign; magnitude below divisor fits
          ga_d = gb_q;
          gb_d = ga_q[W-1] ? (~v_r + W'(1)) : v_r;
          state_d = S_GCHK;
        end
      end
      S_DN: begin
        if (v_done) begin
          num_d = gq; ovf_d = ovf_q | gq_ovf;
          v_start = 1'b1; v_a = fmag(den_q); v_b = fmag(ga_q);
          sa_d = den_q; sb_d = ga_q; state_d = S_DD;
        end
      end
      S_DD: begin
        if (v_done) begin
          den_d = gq; ovf_d = ovf_q | gq_ovf; state_d = S_OUTF;
        end
      end
      S_OUTF: begin
        if (!ovld_q || out_o.ready) begin
          on_d = to_out(num_q); od_d = to_out(den_q);
          ov_d = ovf_q | out_bad(num_q) | out_bad(den_q);
          oz_d = zd_q; ovld_d = 1'b1;
          accn_d = '0; accd_d = W'(1); ovf_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = ovld_q;
  assign out_o.sum_numerator = on_q;
  assign out_o.sum_denominator = od_q;
  assign out_o.overflow = ov_q;
  assign out_o.zero_divisor = oz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; accn_q <= '0; accd_q <= W'(1); ovf_q <= 1'b0; ovld_q <= 1'b0;
    end else begin
      state_q <= state_d; accn_q <= accn_d; accd_q <= accd_d; ovf_q <= ovf_d;
      ovld_q <= ovld_d;
    end
  end
  always_ff @(posedge clk_i) begin
    n_q <= n_d; d_q <= d_d; t1_q <= t1_d; num_q <= num_d; den_q <= den_d;
    ga_q <= ga_d; gb_q <= gb_d; last_q <= last_d; zd_q <= zd_d; sa_q <= sa_d;
    sb_q <= sb_d; on_q <= on_d; od_q <= od_d; ov_q <= ov_d; oz_q <= oz_d;
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (state_q == S_IDLE)) else $error("ready outside idle");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.sum_numerator))
    else $error("result beat dropped");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUTF) && (state_d == S_IDLE) |=> (accd_q == W'(1)) && !ovf_q)
    else $error("sum not cleared");
`endif
endmodule
